@@ hw/rtl/wmbus_thp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmbus_thp_pkg
// Shared types and constants of the wireless M-Bus telegram header parser:
// parse phases, CI codes, header lengths, register indexes and beat formats.
// ----------------------------------------------------------------------------
package wmbus_thp_pkg;

    // Parse phase of the header chain.
    typedef enum logic [2:0] {
        PH_LINK,
        PH_ELL,
        PH_AFL_LEN,
        PH_AFL_SKIP,
        PH_TPL,
        PH_DONE
    } t_phase;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CBC_WITH_IV    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CBC_WITHOUT_IV = 1'b1;
    localparam logic [CFG_DATA_W-1:0]  CBC_WITH_IV_RESET    = 5'd5;
    localparam logic [CFG_DATA_W-1:0]  CBC_WITHOUT_IV_RESET = 5'd7;

    // CI codes.
    localparam logic [7:0] CI_ELL_I          = 8'h8C;
    localparam logic [7:0] CI_ELL_II         = 8'h8D;
    localparam logic [7:0] CI_ELL_III        = 8'h8E;
    localparam logic [7:0] CI_ELL_IV         = 8'h8F;
    localparam logic [7:0] CI_AFL            = 8'h90;
    localparam logic [7:0] CI_TPL_LONG       = 8'h72;
    localparam logic [7:0] CI_TPL_LONG_ALT   = 8'h73;
    localparam logic [7:0] CI_TPL_SHORT      = 8'h7A;
    localparam logic [7:0] CI_TPL_SHORT_ALT  = 8'h77;
    localparam logic [7:0] CI_MFCT_FIRST     = 8'hA0;
    localparam logic [7:0] CI_MFCT_LAST      = 8'hB7;

    // Header lengths in bytes after the CI.
    localparam logic [7:0] TPL_LONG_LEN  = 8'd12;
    localparam logic [7:0] TPL_SHORT_LEN = 8'd4;

    // Header flag masks.
    localparam logic [3:0] FLAG_ELL  = 4'b0001;
    localparam logic [3:0] FLAG_TPL  = 4'b0010;
    localparam logic [3:0] FLAG_LONG = 4'b0100;
    localparam logic [3:0] FLAG_MFCT = 4'b1000;

    // Input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    // Result tdata, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] sizes;
        logic [8:0]  security;
        logic [15:0] tpl_cfg;
        logic [31:0] tpl_ver_type_acc_status;
        logic [15:0] tpl_manuf;
        logic [15:0] ell_control_access;
        logic [23:0] dll_version_type_ci;
        logic [31:0] dll_id;
        logic [15:0] link_manuf;
        logic [7:0]  c_field;
        logic [3:0]  flags;
    } t_out_data;

    typedef struct packed {
        logic      ok;
        t_out_data data;
    } t_result;

    // Length of an extended link header after its CI.
    function automatic logic [7:0] ell_length(input logic [7:0] ci);
        logic [7:0] len;
        case (ci)
            CI_ELL_I:   len = 8'd2;
            CI_ELL_II:  len = 8'd8;
            CI_ELL_III: len = 8'd10;
            default:    len = 8'd16;
        endcase
        return len;
    endfunction

endpackage

@@ hw/rtl/wmbus_thp_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmbus_thp_in_stage
// Input register: holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module wmbus_thp_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  wmbus_thp_pkg::t_beat i_beat,
    input  logic                 i_take,
    output logic                 o_valid,
    output wmbus_thp_pkg::t_beat o_beat
);
    import wmbus_thp_pkg::*;

    logic  r_valid;
    t_beat r_beat;

    // Free when empty or when the held beat leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

@@ hw/rtl/wmbus_thp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmbus_thp_core
// Header chain parser: per-frame state, CI decode and result formation.
// ----------------------------------------------------------------------------
module wmbus_thp_core #(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [wmbus_thp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [wmbus_thp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                      i_beat_valid,
    input  wmbus_thp_pkg::t_beat                      i_beat,
    input  logic                                      i_out_free,
    output logic                                      o_take,
    output logic                                      o_load,
    output wmbus_thp_pkg::t_result                    o_result
);
    import wmbus_thp_pkg::*;

    localparam logic [7:0] MaxPos = 8'(MAX_FRAME_BYTES);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_cbc_iv;
    logic [CFG_DATA_W-1:0] r_cbc_noiv;

    // Frame state.
    t_phase      r_phase,        n_phase;
    logic [7:0]  r_pos,          n_pos;
    logic [7:0]  r_skip,         n_skip;
    logic        r_overflow,     n_overflow;
    logic [7:0]  r_c_field,      n_c_field;
    logic [15:0] r_link_manuf,   n_link_manuf;
    logic [31:0] r_dll_id,       n_dll_id;
    logic [15:0] r_dll_ver_type, n_dll_ver_type;
    logic [7:0]  r_ci,           n_ci;
    logic [3:0]  r_flags,        n_flags;
    logic [15:0] r_ell,          n_ell;
    logic [15:0] r_tpl_manuf,    n_tpl_manuf;
    logic [31:0] r_tpl_vtas,     n_tpl_vtas;
    logic [15:0] r_tpl_cfg,      n_tpl_cfg;
    logic [7:0]  r_header_end,   n_header_end;

    // CI decode of the current byte.
    t_phase      ci_phase;
    logic [7:0]  ci_skip;
    logic [3:0]  ci_flags;
    logic        enter;
    logic [7:0]  b;
    logic [7:0]  ell_len;

    // Result helpers.
    logic [4:0]  mode;
    logic [3:0]  blocks;
    logic        ok;

    assign b       = i_beat.data_byte;
    assign ell_len = ell_length(r_ci);

    // A last beat waits for room in the output register.
    assign o_take = i_beat_valid && (!i_beat.last_byte || i_out_free);
    assign o_load = o_take && i_beat.last_byte;

    // Decode what the byte would start if it is read as a CI.
    always_comb begin
        ci_phase = PH_DONE;
        ci_skip  = 8'd0;
        ci_flags = 4'd0;
        if (b inside {CI_ELL_I, CI_ELL_II, CI_ELL_III, CI_ELL_IV}) begin
            ci_phase = PH_ELL;
            ci_skip  = ell_length(b);
            ci_flags = FLAG_ELL;
        end else if (b == CI_AFL) begin
            ci_phase = PH_AFL_LEN;
        end else if (b inside {CI_TPL_LONG, CI_TPL_LONG_ALT}) begin
            ci_phase = PH_TPL;
            ci_skip  = TPL_LONG_LEN;
            ci_flags = FLAG_TPL | FLAG_LONG;
        end else if (b inside {CI_TPL_SHORT, CI_TPL_SHORT_ALT}) begin
            ci_phase = PH_TPL;
            ci_skip  = TPL_SHORT_LEN;
            ci_flags = FLAG_TPL;
        end else if (b inside {[CI_MFCT_FIRST:CI_MFCT_LAST]}) begin
            ci_flags = FLAG_MFCT;
        end else begin
            // Unknown CI: transport without header, the rest is payload.
            ci_flags = FLAG_TPL;
        end
    end

    // Next state of the parser for the byte taken this cycle.
    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_skip         = r_skip;
        n_overflow     = r_overflow;
        n_c_field      = r_c_field;
        n_link_manuf   = r_link_manuf;
        n_dll_id       = r_dll_id;
        n_dll_ver_type = r_dll_ver_type;
        n_ci           = r_ci;
        n_flags        = r_flags;
        n_ell          = r_ell;
        n_tpl_manuf    = r_tpl_manuf;
        n_tpl_vtas     = r_tpl_vtas;
        n_tpl_cfg      = r_tpl_cfg;
        n_header_end   = r_header_end;
        enter          = 1'b0;
        if (o_take) begin
            if (r_pos >= MaxPos) begin
                n_overflow = 1'b1;
            end else begin
                n_pos = r_pos + 8'd1;
                case (r_phase)
                    PH_LINK: begin
                        // Byte 0 is the length field and is not used.
                        case (r_pos)
                            8'd1:    n_c_field            = b;
                            8'd2:    n_link_manuf[7:0]    = b;
                            8'd3:    n_link_manuf[15:8]   = b;
                            8'd4:    n_dll_id[7:0]        = b;
                            8'd5:    n_dll_id[15:8]       = b;
                            8'd6:    n_dll_id[23:16]      = b;
                            8'd7:    n_dll_id[31:24]      = b;
                            8'd8:    n_dll_ver_type[15:8] = b;
                            8'd9:    n_dll_ver_type[7:0]  = b;
                            8'd10:   enter                = 1'b1;
                            default: ;
                        endcase
                    end
                    PH_ELL: begin
                        if (r_skip == 8'd0) begin
                            enter = 1'b1;
                        end else begin
                            // Control byte first, then the access number.
                            if (r_skip == ell_len) begin
                                n_ell[15:8] = b;
                            end else if (r_skip == ell_len - 8'd1) begin
                                n_ell[7:0] = b;
                            end
                            n_skip = r_skip - 8'd1;
                        end
                    end
                    PH_AFL_LEN: begin
                        n_skip  = b;
                        n_phase = PH_AFL_SKIP;
                    end
                    PH_AFL_SKIP: begin
                        if (r_skip == 8'd0) begin
                            enter = 1'b1;
                        end else begin
                            n_skip = r_skip - 8'd1;
                        end
                    end
                    PH_TPL: begin
                        // The long header ends in these eight bytes, the short one in the last four,
                        // counted down by the remaining length.
                        case (r_skip)
                            8'd8:    n_tpl_manuf[7:0]   = b;
                            8'd7:    n_tpl_manuf[15:8]  = b;
                            8'd6:    n_tpl_vtas[31:24]  = b;
                            8'd5:    n_tpl_vtas[23:16]  = b;
                            8'd4:    n_tpl_vtas[15:8]   = b;
                            8'd3:    n_tpl_vtas[7:0]    = b;
                            8'd2:    n_tpl_cfg[7:0]     = b;
                            8'd1:    n_tpl_cfg[15:8]    = b;
                            default: ;
                        endcase
                        n_skip = r_skip - 8'd1;
                        if (r_skip == 8'd1) begin
                            n_phase      = PH_DONE;
                            n_header_end = r_pos + 8'd1;
                        end
                    end
                    default: ;
                endcase
                if (enter) begin
                    n_ci    = b;
                    n_flags = r_flags | ci_flags;
                    n_phase = ci_phase;
                    n_skip  = ci_skip;
                    if (ci_phase == PH_DONE) begin
                        n_header_end = r_pos + 8'd1;
                    end
                end
            end
        end
    end

    // Result of the frame as it stands after this byte.
    always_comb begin
        mode   = 5'd0;
        blocks = 4'd0;
        if (((n_flags & FLAG_TPL) != 4'd0) && ((n_flags & FLAG_MFCT) == 4'd0)) begin
            mode = n_tpl_cfg[12:8];
            if (mode == r_cbc_iv || mode == r_cbc_noiv) begin
                blocks = n_tpl_cfg[7:4];
            end
        end
        ok = !n_overflow && (n_phase == PH_DONE);
        o_result.ok                           = ok;
        o_result.data                         = '0;
        if (ok) begin
            o_result.data.flags                   = n_flags;
            o_result.data.c_field                 = n_c_field;
            o_result.data.link_manuf              = n_link_manuf;
            o_result.data.dll_id                  = n_dll_id;
            o_result.data.dll_version_type_ci     = {n_dll_ver_type, n_ci};
            o_result.data.ell_control_access      = n_ell;
            o_result.data.tpl_manuf               = n_tpl_manuf;
            o_result.data.tpl_ver_type_acc_status = n_tpl_vtas;
            o_result.data.tpl_cfg                 = n_tpl_cfg;
            o_result.data.security                = {mode, blocks};
            o_result.data.sizes                   = {n_header_end, n_pos - n_header_end};
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cbc_iv   <= CBC_WITH_IV_RESET;
            r_cbc_noiv <= CBC_WITHOUT_IV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CBC_WITH_IV:    r_cbc_iv   <= i_cfg_wdata;
                CFG_CBC_WITHOUT_IV: r_cbc_noiv <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frame state; the last byte of a frame clears it for the next one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_load) begin
            r_phase        <= PH_LINK;
            r_pos          <= 8'd0;
            r_skip         <= 8'd0;
            r_overflow     <= 1'b0;
            r_c_field      <= 8'd0;
            r_link_manuf   <= 16'd0;
            r_dll_id       <= 32'd0;
            r_dll_ver_type <= 16'd0;
            r_ci           <= 8'd0;
            r_flags        <= 4'd0;
            r_ell          <= 16'd0;
            r_tpl_manuf    <= 16'd0;
            r_tpl_vtas     <= 32'd0;
            r_tpl_cfg      <= 16'd0;
            r_header_end   <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_skip         <= n_skip;
            r_overflow     <= n_overflow;
            r_c_field      <= n_c_field;
            r_link_manuf   <= n_link_manuf;
            r_dll_id       <= n_dll_id;
            r_dll_ver_type <= n_dll_ver_type;
            r_ci           <= n_ci;
            r_flags        <= n_flags;
            r_ell          <= n_ell;
            r_tpl_manuf    <= n_tpl_manuf;
            r_tpl_vtas     <= n_tpl_vtas;
            r_tpl_cfg      <= n_tpl_cfg;
            r_header_end   <= n_header_end;
        end
    end

`ifndef SYNTHESIS
    // The byte counter stops at the frame limit.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= MaxPos)
        else $error("byte position beyond frame limit");

    // Overflow is only flagged once the counter has reached the limit.
    a_overflow_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_pos == MaxPos))
        else $error("overflow flagged below frame limit");

    // A finished header chain always extends past the link header.
    a_header_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_header_end >= 8'd11))
        else $error("header end inside link header");

    // After the last byte the parser is back at the start of a frame.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> (r_pos == 8'd0 && r_phase == PH_LINK && !r_overflow))
        else $error("frame state not cleared after last byte");

    // Transport header countdown stays within the long header length.
    a_tpl_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TPL) |-> (r_skip != 8'd0 && r_skip <= TPL_LONG_LEN))
        else $error("transport header countdown out of range");
`endif

endmodule

@@ hw/rtl/wmbus_thp_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmbus_thp_out_reg
// Result register: holds one parsed header result until it is taken.
// ----------------------------------------------------------------------------
module wmbus_thp_out_reg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  wmbus_thp_pkg::t_result i_result,
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output wmbus_thp_pkg::t_result o_result
);
    import wmbus_thp_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new result when empty or when the held one is taken now.
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ hw/rtl/wmbus_telegram_header_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmbus_telegram_header_parser
// Wireless M-Bus telegram header parser: link, extended link, AFL and
// transport headers of a byte-streamed frame, one result per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle and keeps taking bytes
// while a finished result waits at the output. A byte is parsed from an
// input register; a frame's result is loaded into the output register
// with its last byte. Only a last byte can stall the input: it waits
// while the output register still holds an untaken result. Security mode
// registers are written through the configuration port; the user must do
// so only while no frame is in progress; the block does not enforce it.
module wmbus_telegram_header_parser #(
    parameter int MAX_FRAME_BYTES = 255
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration
    input  logic                                  i_cfg_we,
    input  logic [wmbus_thp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wmbus_thp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Frame bytes
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [7:0]                            i_s_axis_tdata,  // data_byte[7:0]
    input  logic                                  i_s_axis_tlast,  // last_byte
    // Header results
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // flags[3:0], c_field[11:4], link_manuf[27:12], dll_id[59:28],
    // dll_version_type_ci[83:60], ell_control_access[99:84],
    // tpl_manuf[115:100], tpl_ver_type_acc_status[147:116],
    // tpl_cfg[163:148], security[172:164], sizes[188:173], zero[191:189]
    output logic [191:0]                          o_m_axis_tdata,
    output logic                                  o_m_axis_tuser   // ok
);
    import wmbus_thp_pkg::*;

    t_beat   s_in_beat;
    t_beat   s_held_beat;
    logic    s_held_valid;
    logic    s_take;
    logic    s_load;
    logic    s_out_free;
    t_result s_result;
    t_result s_out_result;

    assign s_in_beat.data_byte = i_s_axis_tdata;
    assign s_in_beat.last_byte = i_s_axis_tlast;

    // Input register.
    wmbus_thp_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_beat  (s_in_beat),
        .i_take  (s_take),
        .o_valid (s_held_valid),
        .o_beat  (s_held_beat)
    );

    // Header chain parser.
    wmbus_thp_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_beat_valid (s_held_valid),
        .i_beat       (s_held_beat),
        .i_out_free   (s_out_free),
        .o_take       (s_take),
        .o_load       (s_load),
        .o_result     (s_result)
    );

    // Result register.
    wmbus_thp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_load),
        .i_result (s_result),
        .o_free   (s_out_free),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (s_out_result)
    );

    assign o_m_axis_tdata = s_out_result.data;
    assign o_m_axis_tuser = s_out_result.ok;

endmodule
